// ===== src/gclts_pkg.sv =====
// shared types, constants and tile lookup for the lightmap tile select block
package gclts_pkg;

   localparam int CELL_W   = 14;
   localparam int MASK_W   = 8;
   localparam int TILE_W   = 7;
   localparam int FACE_CNT = 6;

   typedef logic [CELL_W-1:0]        cell_type;
   typedef logic [MASK_W-1:0]        mask_type;
   typedef logic signed [TILE_W-1:0] tile_type;

   // stage advance enables handed to each face lane
   typedef struct packed {
      logic mid;
      logic out;
   } adv_type;

   // face order, also the order of the result fields
   localparam int FACE_FLOOR = 0;
   localparam int FACE_CEIL  = 1;
   localparam int FACE_NORTH = 2;
   localparam int FACE_SOUTH = 3;
   localparam int FACE_WEST  = 4;
   localparam int FACE_EAST  = 5;

   // descriptor bit positions
   localparam int BIT_VALID  = 0;
   localparam int BIT_FLOOR  = 1;
   localparam int BIT_CEIL   = 2;
   localparam int BIT_WALL   = 3;
   localparam int BIT_DOOR   = 7;
   localparam int BIT_STAIRS = 11;
   localparam int BIT_ORIENT = 12;

   // directions
   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_S = 2'd1;
   localparam logic [1:0] DIR_W = 2'd2;
   localparam logic [1:0] DIR_E = 2'd3;

   // stairs orientation facing the cell from each side
   localparam logic [1:0] ORIENT_FROM_N = 2'd0;
   localparam logic [1:0] ORIENT_FROM_S = 2'd2;
   localparam logic [1:0] ORIENT_FROM_W = 2'd1;
   localparam logic [1:0] ORIENT_FROM_E = 2'd3;

   // mask bits: edges then corners
   localparam mask_type M_N  = 8'h01;
   localparam mask_type M_S  = 8'h02;
   localparam mask_type M_W  = 8'h04;
   localparam mask_type M_E  = 8'h08;
   localparam mask_type M_NW = 8'h10;
   localparam mask_type M_NE = 8'h20;
   localparam mask_type M_SW = 8'h40;
   localparam mask_type M_SE = 8'h80;

   localparam tile_type TILE_NONE = 7'h7F;

   // wall or door in a direction, no validity check
   function automatic logic blk(input cell_type d, input logic [1:0] dir);
      blk = d[BIT_WALL + int'(dir)] | d[BIT_DOOR + int'(dir)];
   endfunction

   function automatic logic nblk(input cell_type d, input logic [1:0] dir);
      nblk = d[BIT_VALID] & blk(d, dir);
   endfunction

   function automatic logic nfloor(input cell_type d);
      nfloor = d[BIT_VALID] & d[BIT_FLOOR];
   endfunction

   function automatic logic nceil(input cell_type d);
      nceil = d[BIT_VALID] & d[BIT_CEIL];
   endfunction

   function automatic logic nstairs(input cell_type d, input logic [1:0] orient);
      nstairs = d[BIT_VALID] & d[BIT_STAIRS] & (d[BIT_ORIENT+1:BIT_ORIENT] == orient);
   endfunction

   // pack edge and corner flags into a raw mask
   function automatic mask_type pack_mask(input logic n, input logic s, input logic w,
                                          input logic e, input logic nw, input logic ne,
                                          input logic sw, input logic se);
      pack_mask = {se, sw, ne, nw, e, w, s, n};
   endfunction

   // cleaned mask to tile index
   function automatic tile_type tile_lookup(input mask_type m);
      tile_type t;
      unique case (m)
         M_N | M_W | M_E:               t = 7'd0;
         M_W | M_E:                     t = 7'd1;
         M_S | M_W | M_E:               t = 7'd2;
         M_N | M_S | M_W:               t = 7'd3;
         M_N | M_S:                     t = 7'd4;
         M_N | M_S | M_E:               t = 7'd5;
         M_N | M_W:                     t = 7'd6;
         M_N:                           t = 7'd7;
         M_N | M_E:                     t = 7'd8;
         M_W:                           t = 7'd9;
         M_E:                           t = 7'd10;
         M_S | M_W:                     t = 7'd11;
         M_S:                           t = 7'd12;
         M_S | M_E:                     t = 7'd13;
         M_N | M_S | M_W | M_E:         t = 7'd14;
         M_W | M_NE | M_SE:             t = 7'd15;
         M_N | M_SW | M_SE:             t = 7'd16;
         M_E | M_NW | M_SW:             t = 7'd17;
         M_S | M_NW | M_NE:             t = 7'd18;
         M_NW | M_NE | M_SW | M_SE:     t = 7'd19;
         M_W | M_NE:                    t = 7'd20;
         M_N | M_SE:                    t = 7'd21;
         M_E | M_SW:                    t = 7'd22;
         M_S | M_NW:                    t = 7'd23;
         M_NE:                          t = 7'd24;
         M_W | M_SE:                    t = 7'd25;
         M_N | M_SW:                    t = 7'd26;
         M_E | M_NW:                    t = 7'd27;
         M_S | M_NE:                    t = 7'd28;
         M_SE:                          t = 7'd29;
         M_NE | M_SE:                   t = 7'd30;
         M_SW | M_SE:                   t = 7'd31;
         M_NW | M_SW:                   t = 7'd32;
         M_NW | M_NE:                   t = 7'd33;
         M_SW:                          t = 7'd34;
         M_NW:                          t = 7'd35;
         M_N | M_W | M_SE:              t = 7'd36;
         M_N | M_E | M_SW:              t = 7'd37;
         M_S | M_E | M_NW:              t = 7'd38;
         M_S | M_W | M_NE:              t = 7'd39;
         M_NW | M_NE | M_SW:            t = 7'd40;
         M_NW | M_NE | M_SE:            t = 7'd41;
         M_NE | M_SW | M_SE:            t = 7'd42;
         M_NW | M_SW | M_SE:            t = 7'd43;
         M_NE | M_SW:                   t = 7'd44;
         M_NW | M_SE:                   t = 7'd45;
         default:                       t = TILE_NONE;
      endcase
      tile_lookup = t;
   endfunction

endpackage

// ===== src/gclts_face_pipe.sv =====
// one face lane: corner cleanup stage, then tile lookup stage
module gclts_face_pipe (
   input  logic                clock,
   input  gclts_pkg::adv_type  adv,
   input  logic                face_present,
   input  gclts_pkg::mask_type raw_mask,
   output gclts_pkg::tile_type tile
);

   gclts_pkg::mask_type clean_in, clean_ff;
   logic                present_ff;
   gclts_pkg::tile_type tile_in, tile_ff;

   // drop a corner when either adjacent edge is set
   always_comb begin
      clean_in      = raw_mask;
      clean_in[4]   = raw_mask[4] & ~raw_mask[0] & ~raw_mask[2];
      clean_in[5]   = raw_mask[5] & ~raw_mask[0] & ~raw_mask[3];
      clean_in[6]   = raw_mask[6] & ~raw_mask[1] & ~raw_mask[2];
      clean_in[7]   = raw_mask[7] & ~raw_mask[1] & ~raw_mask[3];
   end

   assign tile_in = present_ff ? gclts_pkg::tile_lookup(clean_ff) : gclts_pkg::TILE_NONE;

   always_ff @(posedge clock) begin
      if (adv.mid) begin
         clean_ff   <= clean_in;
         present_ff <= face_present;
      end
      if (adv.out) begin
         tile_ff <= tile_in;
      end
   end

   assign tile = tile_ff;

endmodule

// ===== src/grid_cell_lightmap_tile_select_core.sv =====
// top level of the voxel cell lightmap tile select pipeline
//
// usage
//   req channel: one item per cell, the descriptors of the cell and its six
//   neighbors packed in req_tdata (14 bits each, center first)
//   rsp channel: one item per request, six signed 7-bit tile indices
//   (floor, ceiling, north, south, west, east), -1 where the face is absent
//   or its occlusion mask has no tile
// pipeline
//   stage 1 gathers the raw edge and corner bits of every face
//   stage 2 clears corners next to set edges
//   stage 3 maps each mask through the 46-entry tile table; it is the
//   output register
// rsp_tvalid rises once the item has passed the stage 1, 2 and 3 registers;
// throughput is one item per cycle while rsp_tready stays high;
// a stage takes a new item whenever it is empty or the stage after it moves,
// so bubbles collapse and an item enters while a result still waits
// when rsp_tready is low the full stages hold and req_tready falls once all
// three stages are full; nothing is lost or repeated
// reset clears the stage valid bits; the pipeline is empty after reset
module grid_cell_lightmap_tile_select_core (
   input  logic         clock,
   input  logic         reset,
   // req_tdata, low bit up: center_cell, north_nbr, south_nbr, west_nbr,
   // east_nbr, up_nbr, down_nbr (14 bits each), 6 zero pad bits
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,
   // rsp_tdata, low bit up: floor_tile, ceiling_tile, north_tile,
   // south_tile, west_tile, east_tile (7 bits each, signed), 6 zero pad bits
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata
);

   localparam int CW = gclts_pkg::CELL_W;

   gclts_pkg::cell_type c, no, so, we, ea, up, dn;

   assign c  = req_tdata[0*CW +: CW];
   assign no = req_tdata[1*CW +: CW];
   assign so = req_tdata[2*CW +: CW];
   assign we = req_tdata[3*CW +: CW];
   assign ea = req_tdata[4*CW +: CW];
   assign up = req_tdata[5*CW +: CW];
   assign dn = req_tdata[6*CW +: CW];

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   assign adv3 = ~v3_ff | rsp_tready;
   assign adv2 = ~v2_ff | adv3;
   assign adv1 = ~v1_ff | adv2;

   assign req_tready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // stage 1: raw masks and face presence
   gclts_pkg::mask_type raw_in [gclts_pkg::FACE_CNT];
   gclts_pkg::mask_type raw_ff [gclts_pkg::FACE_CNT];
   logic [gclts_pkg::FACE_CNT-1:0] present_in, present_ff;

   logic c_n, c_s, c_w, c_e;
   logic cf, cc;

   always_comb begin
      c_n = gclts_pkg::blk(c, gclts_pkg::DIR_N);
      c_s = gclts_pkg::blk(c, gclts_pkg::DIR_S);
      c_w = gclts_pkg::blk(c, gclts_pkg::DIR_W);
      c_e = gclts_pkg::blk(c, gclts_pkg::DIR_E);
      cf  = c[gclts_pkg::BIT_FLOOR];
      cc  = c[gclts_pkg::BIT_CEIL];

      present_in[gclts_pkg::FACE_FLOOR] = cf;
      present_in[gclts_pkg::FACE_CEIL]  = cc;
      present_in[gclts_pkg::FACE_NORTH] = c[gclts_pkg::BIT_WALL + 0];
      present_in[gclts_pkg::FACE_SOUTH] = c[gclts_pkg::BIT_WALL + 1];
      present_in[gclts_pkg::FACE_WEST]  = c[gclts_pkg::BIT_WALL + 2];
      present_in[gclts_pkg::FACE_EAST]  = c[gclts_pkg::BIT_WALL + 3];

      // floor edges also count stairs that lead onto the cell
      raw_in[gclts_pkg::FACE_FLOOR] = gclts_pkg::pack_mask(
         c_n | gclts_pkg::nstairs(no, gclts_pkg::ORIENT_FROM_N),
         c_s | gclts_pkg::nstairs(so, gclts_pkg::ORIENT_FROM_S),
         c_w | gclts_pkg::nstairs(we, gclts_pkg::ORIENT_FROM_W),
         c_e | gclts_pkg::nstairs(ea, gclts_pkg::ORIENT_FROM_E),
         gclts_pkg::nblk(no, gclts_pkg::DIR_W) | gclts_pkg::nblk(we, gclts_pkg::DIR_N),
         gclts_pkg::nblk(no, gclts_pkg::DIR_E) | gclts_pkg::nblk(ea, gclts_pkg::DIR_N),
         gclts_pkg::nblk(so, gclts_pkg::DIR_W) | gclts_pkg::nblk(we, gclts_pkg::DIR_S),
         gclts_pkg::nblk(so, gclts_pkg::DIR_E) | gclts_pkg::nblk(ea, gclts_pkg::DIR_S));

      // ceiling is seen from below, so west and east swap
      raw_in[gclts_pkg::FACE_CEIL] = gclts_pkg::pack_mask(
         c_n, c_s, c_e, c_w,
         gclts_pkg::nblk(no, gclts_pkg::DIR_E) | gclts_pkg::nblk(ea, gclts_pkg::DIR_N),
         gclts_pkg::nblk(no, gclts_pkg::DIR_W) | gclts_pkg::nblk(we, gclts_pkg::DIR_N),
         gclts_pkg::nblk(so, gclts_pkg::DIR_E) | gclts_pkg::nblk(ea, gclts_pkg::DIR_S),
         gclts_pkg::nblk(so, gclts_pkg::DIR_W) | gclts_pkg::nblk(we, gclts_pkg::DIR_S));

      // walls: top edge is the ceiling, bottom edge the floor
      raw_in[gclts_pkg::FACE_NORTH] = gclts_pkg::pack_mask(
         cc, cf, c_w, c_e,
         gclts_pkg::nblk(up, gclts_pkg::DIR_W) | gclts_pkg::nceil(we),
         gclts_pkg::nblk(up, gclts_pkg::DIR_E) | gclts_pkg::nceil(ea),
         gclts_pkg::nblk(dn, gclts_pkg::DIR_W) | gclts_pkg::nfloor(we),
         gclts_pkg::nblk(dn, gclts_pkg::DIR_E) | gclts_pkg::nfloor(ea));

      raw_in[gclts_pkg::FACE_SOUTH] = gclts_pkg::pack_mask(
         cc, cf, c_e, c_w,
         gclts_pkg::nblk(up, gclts_pkg::DIR_E) | gclts_pkg::nceil(ea),
         gclts_pkg::nblk(up, gclts_pkg::DIR_W) | gclts_pkg::nceil(we),
         gclts_pkg::nblk(dn, gclts_pkg::DIR_E) | gclts_pkg::nfloor(ea),
         gclts_pkg::nblk(dn, gclts_pkg::DIR_W) | gclts_pkg::nfloor(we));

      raw_in[gclts_pkg::FACE_WEST] = gclts_pkg::pack_mask(
         cc, cf, c_s, c_n,
         gclts_pkg::nblk(up, gclts_pkg::DIR_S) | gclts_pkg::nceil(so),
         gclts_pkg::nblk(up, gclts_pkg::DIR_N) | gclts_pkg::nceil(no),
         gclts_pkg::nblk(dn, gclts_pkg::DIR_S) | gclts_pkg::nfloor(so),
         gclts_pkg::nblk(dn, gclts_pkg::DIR_N) | gclts_pkg::nfloor(no));

      raw_in[gclts_pkg::FACE_EAST] = gclts_pkg::pack_mask(
         cc, cf, c_n, c_s,
         gclts_pkg::nblk(up, gclts_pkg::DIR_N) | gclts_pkg::nceil(no),
         gclts_pkg::nblk(up, gclts_pkg::DIR_S) | gclts_pkg::nceil(so),
         gclts_pkg::nblk(dn, gclts_pkg::DIR_N) | gclts_pkg::nfloor(no),
         gclts_pkg::nblk(dn, gclts_pkg::DIR_S) | gclts_pkg::nfloor(so));
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         raw_ff     <= raw_in;
         present_ff <= present_in;
      end
   end

   // stages 2 and 3: one lane per face
   gclts_pkg::adv_type  lane_adv;
   gclts_pkg::tile_type tile [gclts_pkg::FACE_CNT];

   assign lane_adv.mid = adv2;
   assign lane_adv.out = adv3;

   for (genvar f = 0; f < gclts_pkg::FACE_CNT; f++) begin : g_face
      gclts_face_pipe u_lane (
         .clock        (clock),
         .adv          (lane_adv),
         .face_present (present_ff[f]),
         .raw_mask     (raw_ff[f]),
         .tile         (tile[f])
      );
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {6'd0,
                        tile[gclts_pkg::FACE_EAST],
                        tile[gclts_pkg::FACE_WEST],
                        tile[gclts_pkg::FACE_SOUTH],
                        tile[gclts_pkg::FACE_NORTH],
                        tile[gclts_pkg::FACE_CEIL],
                        tile[gclts_pkg::FACE_FLOOR]};

endmodule

// ===== tb/lightmap_tile_board.sv =====
// scoreboard class, tile predictor and descriptor constants for the lightmap tile select bench
package lightmap_tb_pkg;

   typedef logic [gclts_pkg::FACE_CNT-1:0][gclts_pkg::TILE_W-1:0] tile_set_type;

   localparam gclts_pkg::cell_type D_VALID  = gclts_pkg::cell_type'(1) << gclts_pkg::BIT_VALID;
   localparam gclts_pkg::cell_type D_FLOOR  = gclts_pkg::cell_type'(1) << gclts_pkg::BIT_FLOOR;
   localparam gclts_pkg::cell_type D_CEIL   = gclts_pkg::cell_type'(1) << gclts_pkg::BIT_CEIL;
   localparam gclts_pkg::cell_type D_WALL_N =
      gclts_pkg::cell_type'(1) << (gclts_pkg::BIT_WALL + int'(gclts_pkg::DIR_N));
   localparam gclts_pkg::cell_type D_WALL_S =
      gclts_pkg::cell_type'(1) << (gclts_pkg::BIT_WALL + int'(gclts_pkg::DIR_S));
   localparam gclts_pkg::cell_type D_WALL_W =
      gclts_pkg::cell_type'(1) << (gclts_pkg::BIT_WALL + int'(gclts_pkg::DIR_W));
   localparam gclts_pkg::cell_type D_WALL_E =
      gclts_pkg::cell_type'(1) << (gclts_pkg::BIT_WALL + int'(gclts_pkg::DIR_E));
   localparam gclts_pkg::cell_type D_DOORS  = gclts_pkg::cell_type'(4'hF) << gclts_pkg::BIT_DOOR;
   localparam gclts_pkg::cell_type D_WALLS  = gclts_pkg::cell_type'(4'hF) << gclts_pkg::BIT_WALL;
   localparam gclts_pkg::cell_type D_STAIRS = gclts_pkg::cell_type'(1) << gclts_pkg::BIT_STAIRS;

   // short names for the mask bits used by the table below
   localparam gclts_pkg::mask_type M_N  = gclts_pkg::M_N;
   localparam gclts_pkg::mask_type M_S  = gclts_pkg::M_S;
   localparam gclts_pkg::mask_type M_W  = gclts_pkg::M_W;
   localparam gclts_pkg::mask_type M_E  = gclts_pkg::M_E;
   localparam gclts_pkg::mask_type M_NW = gclts_pkg::M_NW;
   localparam gclts_pkg::mask_type M_NE = gclts_pkg::M_NE;
   localparam gclts_pkg::mask_type M_SW = gclts_pkg::M_SW;
   localparam gclts_pkg::mask_type M_SE = gclts_pkg::M_SE;

   localparam gclts_pkg::mask_type FACE_TILE_MASKS [0:45] = '{
      M_N | M_W | M_E, M_W | M_E, M_S | M_W | M_E, M_N | M_S | M_W,
      M_N | M_S, M_N | M_S | M_E, M_N | M_W, M_N,
      M_N | M_E, M_W, M_E, M_S | M_W,
      M_S, M_S | M_E, M_N | M_S | M_W | M_E, M_W | M_NE | M_SE,
      M_N | M_SW | M_SE, M_E | M_NW | M_SW, M_S | M_NW | M_NE, M_NW | M_NE | M_SW | M_SE,
      M_W | M_NE, M_N | M_SE, M_E | M_SW, M_S | M_NW,
      M_NE, M_W | M_SE, M_N | M_SW, M_E | M_NW,
      M_S | M_NE, M_SE, M_NE | M_SE, M_SW | M_SE,
      M_NW | M_SW, M_NW | M_NE, M_SW, M_NW,
      M_N | M_W | M_SE, M_N | M_E | M_SW, M_S | M_E | M_NW, M_S | M_W | M_NE,
      M_NW | M_NE | M_SW, M_NW | M_NE | M_SE, M_NE | M_SW | M_SE, M_NW | M_SW | M_SE,
      M_NE | M_SW, M_NW | M_SE
   };

   // wall or door on one side, validity not looked at
   function automatic bit side_closed(gclts_pkg::cell_type d, logic [1:0] dir);
      return d[gclts_pkg::BIT_WALL + int'(dir)] | d[gclts_pkg::BIT_DOOR + int'(dir)];
   endfunction

   function automatic bit nbr_closed(gclts_pkg::cell_type d, logic [1:0] dir);
      return d[gclts_pkg::BIT_VALID] & side_closed(d, dir);
   endfunction

   function automatic bit nbr_floor(gclts_pkg::cell_type d);
      return d[gclts_pkg::BIT_VALID] & d[gclts_pkg::BIT_FLOOR];
   endfunction

   function automatic bit nbr_ceil(gclts_pkg::cell_type d);
      return d[gclts_pkg::BIT_VALID] & d[gclts_pkg::BIT_CEIL];
   endfunction

   function automatic bit nbr_stairs(gclts_pkg::cell_type d, logic [1:0] facing);
      return d[gclts_pkg::BIT_VALID] & d[gclts_pkg::BIT_STAIRS]
             & (d[gclts_pkg::BIT_ORIENT +: 2] == facing);
   endfunction

   // corners drop out next to a set edge, then the table decides the tile
   function automatic gclts_pkg::tile_type tile_for_edges(bit n, bit s, bit w, bit e,
                                                          bit nw, bit ne, bit sw, bit se);
      gclts_pkg::mask_type m;
      gclts_pkg::tile_type t;
      m = gclts_pkg::mask_type'({se & ~s & ~e, sw & ~s & ~w, ne & ~n & ~e, nw & ~n & ~w,
                                 e, w, s, n});
      t = gclts_pkg::TILE_NONE;
      for (int i = 0; i < 46; i++) begin
         if (FACE_TILE_MASKS[i] == m) t = gclts_pkg::tile_type'(i);
      end
      return t;
   endfunction

   function automatic tile_set_type predict_tiles(
      gclts_pkg::cell_type c, gclts_pkg::cell_type no, gclts_pkg::cell_type so,
      gclts_pkg::cell_type we, gclts_pkg::cell_type ea,
      gclts_pkg::cell_type up, gclts_pkg::cell_type dn);
      tile_set_type t;
      bit cf, cc;
      cf = c[gclts_pkg::BIT_FLOOR];
      cc = c[gclts_pkg::BIT_CEIL];
      t[gclts_pkg::FACE_FLOOR] = !cf ? gclts_pkg::TILE_NONE : tile_for_edges(
         side_closed(c, gclts_pkg::DIR_N) | nbr_stairs(no, gclts_pkg::ORIENT_FROM_N),
         side_closed(c, gclts_pkg::DIR_S) | nbr_stairs(so, gclts_pkg::ORIENT_FROM_S),
         side_closed(c, gclts_pkg::DIR_W) | nbr_stairs(we, gclts_pkg::ORIENT_FROM_W),
         side_closed(c, gclts_pkg::DIR_E) | nbr_stairs(ea, gclts_pkg::ORIENT_FROM_E),
         nbr_closed(no, gclts_pkg::DIR_W) | nbr_closed(we, gclts_pkg::DIR_N),
         nbr_closed(no, gclts_pkg::DIR_E) | nbr_closed(ea, gclts_pkg::DIR_N),
         nbr_closed(so, gclts_pkg::DIR_W) | nbr_closed(we, gclts_pkg::DIR_S),
         nbr_closed(so, gclts_pkg::DIR_E) | nbr_closed(ea, gclts_pkg::DIR_S));
      // ceiling is seen from below, so west and east swap
      t[gclts_pkg::FACE_CEIL] = !cc ? gclts_pkg::TILE_NONE : tile_for_edges(
         side_closed(c, gclts_pkg::DIR_N), side_closed(c, gclts_pkg::DIR_S),
         side_closed(c, gclts_pkg::DIR_E), side_closed(c, gclts_pkg::DIR_W),
         nbr_closed(no, gclts_pkg::DIR_E) | nbr_closed(ea, gclts_pkg::DIR_N),
         nbr_closed(no, gclts_pkg::DIR_W) | nbr_closed(we, gclts_pkg::DIR_N),
         nbr_closed(so, gclts_pkg::DIR_E) | nbr_closed(ea, gclts_pkg::DIR_S),
         nbr_closed(so, gclts_pkg::DIR_W) | nbr_closed(we, gclts_pkg::DIR_S));
      t[gclts_pkg::FACE_NORTH] = !c[gclts_pkg::BIT_WALL + int'(gclts_pkg::DIR_N)]
         ? gclts_pkg::TILE_NONE : tile_for_edges(
         cc, cf, side_closed(c, gclts_pkg::DIR_W), side_closed(c, gclts_pkg::DIR_E),
         nbr_closed(up, gclts_pkg::DIR_W) | nbr_ceil(we),
         nbr_closed(up, gclts_pkg::DIR_E) | nbr_ceil(ea),
         nbr_closed(dn, gclts_pkg::DIR_W) | nbr_floor(we),
         nbr_closed(dn, gclts_pkg::DIR_E) | nbr_floor(ea));
      t[gclts_pkg::FACE_SOUTH] = !c[gclts_pkg::BIT_WALL + int'(gclts_pkg::DIR_S)]
         ? gclts_pkg::TILE_NONE : tile_for_edges(
         cc, cf, side_closed(c, gclts_pkg::DIR_E), side_closed(c, gclts_pkg::DIR_W),
         nbr_closed(up, gclts_pkg::DIR_E) | nbr_ceil(ea),
         nbr_closed(up, gclts_pkg::DIR_W) | nbr_ceil(we),
         nbr_closed(dn, gclts_pkg::DIR_E) | nbr_floor(ea),
         nbr_closed(dn, gclts_pkg::DIR_W) | nbr_floor(we));
      t[gclts_pkg::FACE_WEST] = !c[gclts_pkg::BIT_WALL + int'(gclts_pkg::DIR_W)]
         ? gclts_pkg::TILE_NONE : tile_for_edges(
         cc, cf, side_closed(c, gclts_pkg::DIR_S), side_closed(c, gclts_pkg::DIR_N),
         nbr_closed(up, gclts_pkg::DIR_S) | nbr_ceil(so),
         nbr_closed(up, gclts_pkg::DIR_N) | nbr_ceil(no),
         nbr_closed(dn, gclts_pkg::DIR_S) | nbr_floor(so),
         nbr_closed(dn, gclts_pkg::DIR_N) | nbr_floor(no));
      t[gclts_pkg::FACE_EAST] = !c[gclts_pkg::BIT_WALL + int'(gclts_pkg::DIR_E)]
         ? gclts_pkg::TILE_NONE : tile_for_edges(
         cc, cf, side_closed(c, gclts_pkg::DIR_N), side_closed(c, gclts_pkg::DIR_S),
         nbr_closed(up, gclts_pkg::DIR_N) | nbr_ceil(no),
         nbr_closed(up, gclts_pkg::DIR_S) | nbr_ceil(so),
         nbr_closed(dn, gclts_pkg::DIR_N) | nbr_floor(no),
         nbr_closed(dn, gclts_pkg::DIR_S) | nbr_floor(so));
      return t;
   endfunction

   class tile_scoreboard;
      tile_set_type expected_tiles[$];
      int unsigned  errors;

      function new();
         errors = 0;
      endfunction

      function void note_cell(logic [103:0] cells);
         expected_tiles.push_back(predict_tiles(cells[13:0], cells[27:14], cells[41:28],
                                                cells[55:42], cells[69:56], cells[83:70],
                                                cells[97:84]));
      endfunction

      function void check_tiles(logic [47:0] data);
         tile_set_type want;
         string        face_name [gclts_pkg::FACE_CNT];
         face_name = '{"floor_tile", "ceiling_tile", "north_tile",
                       "south_tile", "west_tile", "east_tile"};
         if (expected_tiles.size() == 0) begin
            $error("result with no item outstanding: %h", data);
            errors++;
         end else begin
            want = expected_tiles.pop_front();
            for (int f = 0; f < gclts_pkg::FACE_CNT; f++) begin
               if (data[f*gclts_pkg::TILE_W +: gclts_pkg::TILE_W] !== want[f]) begin
                  $error("%s: expected %0d, actual %0d", face_name[f],
                         $signed(want[f]),
                         $signed(data[f*gclts_pkg::TILE_W +: gclts_pkg::TILE_W]));
                  errors++;
               end
            end
         end
      endfunction

      function int unsigned pending();
         return expected_tiles.size();
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// top level bench for the voxel cell lightmap tile select core
module tb_top;

   // no item moving on either channel for this many cycles means a hang;
   // the slowest stretch is a stall at 82 percent idle on either channel, far below this
   localparam int unsigned HANG_LIMIT  = 2000;
   // three register stages; the drain tail at the end outlasts them
   localparam int unsigned DRAIN_TAIL  = 10;
   localparam int unsigned PHASE_ITEMS = 560;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;

   // idle percentages for the current phase
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  quiet_cycles  = 0;

   lightmap_tb_pkg::tile_scoreboard board;

   grid_cell_lightmap_tile_select_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // every accepted result is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_tiles(rsp_tdata);
   end

   // hang watchdog: counts cycles in which no item moves on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
         $display("grid_cell_lightmap_tile_select_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stairs neighbor facing the given orientation
   function automatic gclts_pkg::cell_type stairs_cell(logic [1:0] orient);
      return lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_STAIRS
             | (gclts_pkg::cell_type'(orient) << gclts_pkg::BIT_ORIENT);
   endfunction

   // offer one cell neighborhood, with a random gap in front, and hold it
   // until accepted; valid stays high afterwards so back-to-back items have
   // no bubble unless the next call draws a gap
   task automatic send_cells(gclts_pkg::cell_type c, gclts_pkg::cell_type no,
                             gclts_pkg::cell_type so, gclts_pkg::cell_type we,
                             gclts_pkg::cell_type ea, gclts_pkg::cell_type up,
                             gclts_pkg::cell_type dn);
      logic [103:0] cells;
      cells = {6'b0, dn, up, ea, we, so, no, c};
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cells;
      do @(posedge clock); while (!req_tready);
      board.note_cell(cells);
   endtask

   // hold the sender off until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // random descriptor: sometimes fully random, mostly sparse so that faces
   // land on real tiles instead of crowded masks
   function automatic gclts_pkg::cell_type rand_cell(bit is_center);
      gclts_pkg::cell_type d;
      int unsigned         density;
      if ($urandom_range(3) == 0) begin
         d = gclts_pkg::cell_type'($urandom);
      end else begin
         density = $urandom_range(10, 55);
         for (int b = 0; b < gclts_pkg::CELL_W; b++) d[b] = ($urandom_range(99) < density);
         if (is_center) begin
            if ($urandom_range(99) < 70) d[gclts_pkg::BIT_FLOOR] = 1'b1;
            for (int w = 0; w < 4; w++) begin
               if ($urandom_range(1) == 1) d[gclts_pkg::BIT_WALL + w] = 1'b1;
            end
         end else if ($urandom_range(99) < 85) begin
            d[gclts_pkg::BIT_VALID] = 1'b1;
         end
      end
      return d;
   endfunction

   task automatic random_phase(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_cells(rand_cell(1'b1), rand_cell(1'b0), rand_cell(1'b0), rand_cell(1'b0),
                    rand_cell(1'b0), rand_cell(1'b0), rand_cell(1'b0));
      end
   endtask

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part, slow receiver like the first random phase
      send_idle_pct = 17;
      recv_idle_pct = 82;
      // all clear: no face present anywhere
      send_cells('0, '0, '0, '0, '0, '0, '0);
      // everything set: crowded masks, every face present
      send_cells('1, '1, '1, '1, '1, '1, '1);
      // lone floor with center valid clear: empty mask has no tile
      send_cells(lightmap_tb_pkg::D_FLOOR, '0, '0, '0, '0, '0, '0);
      // center full, no neighbors
      send_cells('1, '0, '0, '0, '0, '0, '0);
      // neighbors full, center empty
      send_cells('0, '1, '1, '1, '1, '1, '1);
      // stairs facing the cell from each side set floor edges
      send_cells(lightmap_tb_pkg::D_FLOOR, stairs_cell(gclts_pkg::ORIENT_FROM_N),
                 '0, '0, '0, '0, '0);
      send_cells(lightmap_tb_pkg::D_FLOOR, '0, stairs_cell(gclts_pkg::ORIENT_FROM_S),
                 '0, '0, '0, '0);
      send_cells(lightmap_tb_pkg::D_FLOOR, '0, '0, stairs_cell(gclts_pkg::ORIENT_FROM_W),
                 '0, '0, '0);
      send_cells(lightmap_tb_pkg::D_FLOOR, '0, '0, '0,
                 stairs_cell(gclts_pkg::ORIENT_FROM_E), '0, '0);
      // stairs turned away do nothing
      send_cells(lightmap_tb_pkg::D_FLOOR, stairs_cell(gclts_pkg::ORIENT_FROM_S),
                 stairs_cell(gclts_pkg::ORIENT_FROM_N), stairs_cell(gclts_pkg::ORIENT_FROM_E),
                 stairs_cell(gclts_pkg::ORIENT_FROM_W), '0, '0);
      // stairs on an invalid neighbor are ignored
      send_cells(lightmap_tb_pkg::D_FLOOR | lightmap_tb_pkg::D_WALL_S,
                 lightmap_tb_pkg::D_STAIRS, '0, '0, '0, '0, '0);
      // invalid neighbors with every other bit set count as absent
      send_cells(lightmap_tb_pkg::D_FLOOR | lightmap_tb_pkg::D_CEIL | lightmap_tb_pkg::D_WALLS,
                 ~lightmap_tb_pkg::D_VALID, ~lightmap_tb_pkg::D_VALID,
                 ~lightmap_tb_pkg::D_VALID, ~lightmap_tb_pkg::D_VALID,
                 ~lightmap_tb_pkg::D_VALID, ~lightmap_tb_pkg::D_VALID);
      // doors alone close floor edges but open no wall face
      send_cells(lightmap_tb_pkg::D_FLOOR | lightmap_tb_pkg::D_CEIL | lightmap_tb_pkg::D_DOORS,
                 '0, '0, '0, '0, '0, '0);
      // ceiling mirror: west wall lands on the east edge
      send_cells(lightmap_tb_pkg::D_CEIL | lightmap_tb_pkg::D_WALL_W, '0, '0, '0, '0, '0, '0);
      send_cells(lightmap_tb_pkg::D_CEIL | lightmap_tb_pkg::D_WALL_N,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_WALL_W, '0, '0,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_WALL_S, '0, '0);
      // single corner from the north neighbor
      send_cells(lightmap_tb_pkg::D_FLOOR,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_WALL_W, '0, '0, '0, '0, '0);
      // same corner dropped by the north edge
      send_cells(lightmap_tb_pkg::D_FLOOR | lightmap_tb_pkg::D_WALL_N,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_WALL_W, '0, '0, '0, '0, '0);
      // four corners, via doors on the side neighbors
      send_cells(lightmap_tb_pkg::D_FLOOR, '0, '0,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_DOORS,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_DOORS, '0, '0);
      // wall faces with up and down blocking and side floors and ceilings
      send_cells(lightmap_tb_pkg::D_FLOOR | lightmap_tb_pkg::D_WALLS,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_CEIL,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_FLOOR,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_CEIL,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_FLOOR,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_WALL_N | lightmap_tb_pkg::D_WALL_W,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_WALL_S | lightmap_tb_pkg::D_WALL_E);
      send_cells(lightmap_tb_pkg::D_CEIL | lightmap_tb_pkg::D_WALLS,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_FLOOR,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_CEIL,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_FLOOR,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_CEIL,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_WALL_S | lightmap_tb_pkg::D_WALL_E,
                 lightmap_tb_pkg::D_VALID | lightmap_tb_pkg::D_WALL_N | lightmap_tb_pkg::D_WALL_W);
      drain_results();

      // random part: slow receiver, then slow sender, then full rate
      send_idle_pct = 17;
      recv_idle_pct = 82;
      random_phase(PHASE_ITEMS);
      drain_results();

      send_idle_pct = 82;
      recv_idle_pct = 17;
      random_phase(PHASE_ITEMS);
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(PHASE_ITEMS);
      drain_results();

      // stray results would show up within the pipeline depth
      repeat (DRAIN_TAIL) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0) begin
         $display("grid_cell_lightmap_tile_select_core regression: pass");
      end else begin
         $display("grid_cell_lightmap_tile_select_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== grid_cell_lightmap_tile_select_core.f =====
src/gclts_pkg.sv
src/gclts_face_pipe.sv
src/grid_cell_lightmap_tile_select_core.sv
tb/lightmap_tile_board.sv
tb/tb_top.sv
